[src/tgp_pkg.sv]
// ----------------------------------------------------------------------------
// tgp_pkg: shared types and constants for the touch-to-pointer block
// Event codes, register indexes, sequencer states, shared-unit control and
// result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tgp_pkg;

  // input event commands
  localparam logic [1:0] CMD_DOWN   = 2'd0;
  localparam logic [1:0] CMD_UP     = 2'd1;
  localparam logic [1:0] CMD_MOTION = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  // result event kinds
  localparam logic [1:0] EV_POS   = 2'd0;
  localparam logic [1:0] EV_BTN   = 2'd1;
  localparam logic [1:0] EV_WHEEL = 2'd2;

  localparam logic BTN_LEFT  = 1'b0;
  localparam logic BTN_RIGHT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  localparam logic [11:0] RST_WIDTH  = 12'd1920;
  localparam logic [11:0] RST_HEIGHT = 12'd1080;
  localparam logic [15:0] RST_GAIN   = 16'd2560;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SINGLE = 2'd1,
    PH_MULTI  = 2'd2,
    PH_ENDED  = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_MULD,
    S_INS,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RD0,
    S_RD1,
    S_RDB,
    S_DECIDE,
    S_SQX,
    S_SQY,
    S_SQS,
    S_SQW,
    S_WMUL,
    S_WDIV,
    S_WDW,
    S_OUT
  } st_t;

  typedef enum logic [1:0] {
    ALU_NOP  = 2'd0,
    ALU_MUL  = 2'd1,
    ALU_SQRT = 2'd2,
    ALU_DIV  = 2'd3
  } alu_op_t;

  // shared unit command: MUL uses a[17:0] x b, SQRT uses a, DIV a / b
  typedef struct packed {
    alu_op_t     op;
    logic [33:0] a;
    logic [15:0] b;
  } alu_ctl_t;

  typedef struct packed {
    logic        busy;
    logic [33:0] prod;
    logic [16:0] root;
    logic [33:0] quot;
  } alu_res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
  } finger_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               button;
    logic               pressed;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] wheel;
  } res_t;

  function automatic res_t mk_pos(input logic [15:0] x, input logic [15:0] y);
    res_t r;
    r = '0;
    r.kind  = EV_POS;
    r.pos_x = x;
    r.pos_y = y;
    return r;
  endfunction

  function automatic res_t mk_btn(input logic b, input logic p);
    res_t r;
    r = '0;
    r.kind    = EV_BTN;
    r.button  = b;
    r.pressed = p;
    return r;
  endfunction

  function automatic res_t mk_whl(input logic signed [15:0] w);
    res_t r;
    r = '0;
    r.kind  = EV_WHEEL;
    r.wheel = w;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/tgp_if.sv]
// ----------------------------------------------------------------------------
// tgp_if: channel interfaces for the touch-to-pointer block
// Touch event input, pointer event output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] finger_id;
  logic [15:0] norm_x;
  logic [15:0] norm_y;
  modport source (output valid, command, finger_id, norm_x, norm_y, input ready);
  modport sink   (input valid, command, finger_id, norm_x, norm_y, output ready);
endinterface

interface tgp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic               button;
  logic               pressed;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [15:0] wheel;
  logic               last;
  modport source (output valid, event_kind, button, pressed, pos_x, pos_y, wheel, last,
                  input ready);
  modport sink   (input valid, event_kind, button, pressed, pos_x, pos_y, wheel, last,
                  output ready);
endinterface

interface tgp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/tgp_ram.sv]
// ----------------------------------------------------------------------------
// tgp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/tgp_alu.sv]
// ----------------------------------------------------------------------------
// tgp_alu: shared arithmetic unit
// Registered 18x16 multiplier, bit-serial integer square root (17 steps)
// and restoring divider (34 steps); root and divider share one shift accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  tgp_pkg::alu_ctl_t ctl,
  output tgp_pkg::alu_res_t res
);
  import tgp_pkg::*;

  logic [33:0] acc_r, acc_nxt;
  logic [19:0] rem_r, rem_nxt;
  logic [16:0] root_r, root_nxt;
  logic [15:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  alu_op_t     mode_r, mode_nxt;
  logic [33:0] prod_r;

  logic [19:0] sq_rem;
  logic [19:0] sq_trial;
  logic [17:0] dv_rem;

  assign sq_rem   = {rem_r[17:0], acc_r[33:32]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign dv_rem   = {rem_r[16:0], acc_r[33]};

  // step logic: load on a start, one root bit or quotient bit a cycle
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    mode_nxt = mode_r;
    if (!busy_r) begin
      unique case (ctl.op)
        ALU_SQRT: begin
          acc_nxt  = ctl.a;
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = 6'd17;
          busy_nxt = 1'b1;
          mode_nxt = ALU_SQRT;
        end
        ALU_DIV: begin
          acc_nxt  = ctl.a;
          rem_nxt  = '0;
          div_nxt  = ctl.b;
          cnt_nxt  = 6'd34;
          busy_nxt = 1'b1;
          mode_nxt = ALU_DIV;
        end
        default: begin
        end
      endcase
    end else begin
      if (mode_r == ALU_SQRT) begin
        acc_nxt = {acc_r[31:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_nxt  = sq_rem - sq_trial;
          root_nxt = {root_r[15:0], 1'b1};
        end else begin
          rem_nxt  = sq_rem;
          root_nxt = {root_r[15:0], 1'b0};
        end
      end else begin
        if (dv_rem >= {2'b00, div_r}) begin
          rem_nxt = {2'b00, dv_rem - {2'b00, div_r}};
          acc_nxt = {acc_r[32:0], 1'b1};
        end else begin
          rem_nxt = {2'b00, dv_rem};
          acc_nxt = {acc_r[32:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mode_r <= ALU_NOP;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    div_r  <= div_nxt;
    if (ctl.op == ALU_MUL) begin
      prod_r <= ctl.a[17:0] * ctl.b;
    end
  end

  assign res.busy = busy_r;
  assign res.prod = prod_r;
  assign res.root = root_r;
  assign res.quot = acc_r;

endmodule

`default_nettype wire

[src/touch_gesture_to_pointer_top.sv]
// Output: the words of one event go out one per cycle while out_ch.ready is high.
// Throughput: one event at a time; the shared unit sets the pace (17-step
//   square root, 34-step divide) together with the finger table scan.
// Reset: synchronous active-low; table empty, phase idle, registers at
//   width 1920, height 1080, gain 2560.
// ----------------------------------------------------------------------------
// touch_gesture_to_pointer_top: touch events to pointer events
// Scales touch positions to pixels, tracks active fingers in an ordered table
// and runs the gesture phase machine on a shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_to_pointer_top #(
  parameter int MAX_FINGERS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  tgp_in_if.sink    in_ch,
  tgp_out_if.source out_ch,
  tgp_cfg_if.sink   cfg_ch
);
  import tgp_pkg::*;

  localparam int CW = $clog2(MAX_FINGERS + 1);
  localparam int IW = $clog2(MAX_FINGERS);

  st_t          st_r, st_nxt;
  phase_t       phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [17:0]  lp_r, lp_nxt;
  logic [11:0]  w_r, h_r;
  logic [15:0]  gain_r;
  logic [1:0]   cmd_r, cmd_nxt;
  logic [15:0]  id_r, id_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  logic [15:0]  px_r, px_nxt, py_r, py_nxt;
  finger_t      a_r, a_nxt, b_r, b_nxt;
  logic [31:0]  sx_r, sx_nxt;
  logic [16:0]  dist_r, dist_nxt;
  logic         wp_r, wp_nxt;
  res_t         res_r [3];
  res_t         res_nxt [3];
  logic [1:0]   nres_r, nres_nxt, k_r, k_nxt;

  // table RAM and shared unit hookup
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  finger_t       ram_wdata, ram_rdata;
  alu_ctl_t      alu_ctl;
  alu_res_t      alu_res;

  tgp_ram #(.WIDTH($bits(finger_t)), .DEPTH(MAX_FINGERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tgp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .res   (alu_res)
  );

  // derived values
  logic         in_ignore, matched, cnt_zero, cnt_one, cnt_ge2, neg;
  logic [16:0]  sumx, sumy;
  logic [15:0]  cx, cy, dx, dy;
  logic [17:0]  mag;
  logic signed [15:0] whl;
  logic [CW-1:0] idx_inc;

  assign in_ignore = (in_ch.command == CMD_RSVD) || (w_r == '0) || (h_r == '0);
  assign matched   = (ram_rdata.id == id_r);
  assign cnt_zero  = (count_r == '0);
  assign cnt_one   = (count_r == CW'(1));
  assign cnt_ge2   = (count_r >= CW'(2));
  assign idx_inc   = idx_r + CW'(1);
  assign sumx      = {1'b0, a_r.x} + {1'b0, b_r.x};
  assign sumy      = {1'b0, a_r.y} + {1'b0, b_r.y};
  assign cx        = sumx[16:1];
  assign cy        = sumy[16:1];
  assign dx        = (a_r.x >= b_r.x) ? a_r.x - b_r.x : b_r.x - a_r.x;
  assign dy        = (a_r.y >= b_r.y) ? a_r.y - b_r.y : b_r.y - a_r.y;
  assign neg       = ({1'b0, dist_r} < lp_r);
  assign mag       = neg ? lp_r - {1'b0, dist_r} : {1'b0, dist_r} - lp_r;

  // wheel saturation
  always_comb begin
    if (neg) begin
      whl = (alu_res.quot > 34'd32768) ? 16'sh8000 : -$signed(alu_res.quot[15:0]);
    end else begin
      whl = (alu_res.quot > 34'd32767) ? 16'sh7FFF : $signed(alu_res.quot[15:0]);
    end
  end

  // configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= RST_WIDTH;
      h_r    <= RST_HEIGHT;
      gain_r <= RST_GAIN;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WIDTH:  w_r    <= cfg_ch.data[11:0];
        REG_HEIGHT: h_r    <= cfg_ch.data[11:0];
        REG_GAIN:   gain_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    lp_nxt    = lp_r;
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    sx_nxt    = sx_r;
    dist_nxt  = dist_r;
    wp_nxt    = wp_r;
    res_nxt   = res_r;
    nres_nxt  = nres_r;
    k_nxt     = k_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          id_nxt  = in_ch.finger_id;
          nx_nxt  = in_ch.norm_x;
          ny_nxt  = in_ch.norm_y;
          if (!in_ignore) begin
            st_nxt = S_MULX;
          end
        end
      end
      S_MULX: st_nxt = S_MULY;
      S_MULY: begin
        px_nxt = alu_res.prod[27:12];
        st_nxt = S_MULD;
      end
      S_MULD: begin
        py_nxt = alu_res.prod[27:12];
        if (cmd_r == CMD_DOWN) begin
          st_nxt = (count_r >= CW'(MAX_FINGERS)) ? S_IDLE : S_INS;
        end else begin
          idx_nxt = '0;
          st_nxt  = S_SRCH_RD;
        end
      end
      S_INS: begin
        count_nxt = count_r + CW'(1);
        st_nxt    = S_RD0;
      end
      S_SRCH_RD: st_nxt = (idx_r >= count_r) ? S_IDLE : S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (matched) begin
          st_nxt = (cmd_r == CMD_MOTION) ? S_RD0 : S_SHIFT_RD;
        end else begin
          idx_nxt = idx_inc;
          st_nxt  = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (idx_inc >= count_r) begin
          count_nxt = count_r - CW'(1);
          st_nxt    = S_RD0;
        end else begin
          st_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        idx_nxt = idx_inc;
        st_nxt  = S_SHIFT_RD;
      end
      S_RD0: st_nxt = S_RD1;
      S_RD1: begin
        a_nxt  = ram_rdata;
        st_nxt = S_RDB;
      end
      S_RDB: begin
        b_nxt  = ram_rdata;
        st_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        k_nxt    = '0;
        nres_nxt = 2'd1;
        st_nxt   = S_OUT;
        priority if (phase_r == PH_IDLE && cnt_one) begin
          res_nxt[0] = mk_pos(a_r.x, a_r.y);
          res_nxt[1] = mk_btn(BTN_LEFT, 1'b1);
          nres_nxt   = 2'd2;
          phase_nxt  = PH_SINGLE;
        end else if (phase_r == PH_SINGLE && cnt_ge2) begin
          res_nxt[0] = mk_btn(BTN_LEFT, 1'b0);
          res_nxt[1] = mk_pos(cx, cy);
          res_nxt[2] = mk_btn(BTN_RIGHT, 1'b1);
          nres_nxt   = 2'd3;
          phase_nxt  = PH_MULTI;
          wp_nxt     = 1'b0;
          st_nxt     = S_SQX;
        end else if (phase_r == PH_SINGLE && cnt_zero) begin
          res_nxt[0] = mk_btn(BTN_LEFT, 1'b0);
          phase_nxt  = PH_IDLE;
        end else if (phase_r == PH_MULTI && !cnt_ge2) begin
          res_nxt[0] = mk_btn(BTN_RIGHT, 1'b0);
          phase_nxt  = cnt_zero ? PH_IDLE : PH_ENDED;
        end else if (phase_r == PH_ENDED && cnt_zero) begin
          phase_nxt = PH_IDLE;
          st_nxt    = S_IDLE;
        end else if (phase_r == PH_SINGLE && cmd_r == CMD_MOTION) begin
          res_nxt[0] = mk_pos(a_r.x, a_r.y);
        end else if (phase_r == PH_MULTI && cmd_r == CMD_UP) begin
          res_nxt[0] = mk_pos(cx, cy);
          wp_nxt     = 1'b0;
          st_nxt     = S_SQX;
        end else if (phase_r == PH_MULTI && cmd_r == CMD_MOTION) begin
          res_nxt[0] = mk_pos(cx, cy);
          wp_nxt     = 1'b1;
          st_nxt     = S_SQX;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_SQX: st_nxt = S_SQY;
      S_SQY: begin
        sx_nxt = alu_res.prod[31:0];
        st_nxt = S_SQS;
      end
      S_SQS: st_nxt = S_SQW;
      S_SQW: begin
        if (!alu_res.busy) begin
          dist_nxt = alu_res.root;
          if (wp_r) begin
            st_nxt = S_WMUL;
          end else begin
            lp_nxt = {1'b0, alu_res.root};
            st_nxt = S_OUT;
          end
        end
      end
      S_WMUL: st_nxt = S_WDIV;
      S_WDIV: st_nxt = S_WDW;
      S_WDW: begin
        if (!alu_res.busy) begin
          lp_nxt = {1'b0, dist_r};
          if (whl != '0) begin
            res_nxt[nres_r] = mk_whl(whl);
            nres_nxt        = nres_r + 2'd1;
          end
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (k_r == nres_r - 2'd1) begin
            st_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs: handshakes, table port and shared-unit commands
  always_comb begin
    in_ch.ready  = (st_r == S_IDLE);
    out_ch.valid = (st_r == S_OUT);
    ram_we       = 1'b0;
    ram_waddr    = idx_r[IW-1:0];
    ram_wdata    = '{id: id_r, x: px_r, y: py_r};
    ram_raddr    = '0;
    alu_ctl      = '{op: ALU_NOP, a: '0, b: '0};
    unique case (st_r)
      S_MULX: alu_ctl = '{op: ALU_MUL, a: {18'd0, nx_r}, b: {4'd0, w_r}};
      S_MULY: alu_ctl = '{op: ALU_MUL, a: {18'd0, ny_r}, b: {4'd0, h_r}};
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = count_r[IW-1:0];
      end
      S_SRCH_RD: ram_raddr = idx_r[IW-1:0];
      S_SRCH_CMP: ram_we = matched && (cmd_r == CMD_MOTION);
      S_SHIFT_RD: ram_raddr = idx_inc[IW-1:0];
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_RD1: ram_raddr = IW'(1);
      S_SQX: alu_ctl = '{op: ALU_MUL, a: {18'd0, dx}, b: dx};
      S_SQY: alu_ctl = '{op: ALU_MUL, a: {18'd0, dy}, b: dy};
      S_SQS: alu_ctl = '{op: ALU_SQRT, a: {2'b00, sx_r} + alu_res.prod, b: '0};
      S_WMUL: alu_ctl = '{op: ALU_MUL, a: {16'd0, mag}, b: gain_r};
      S_WDIV: alu_ctl = '{op: ALU_DIV, a: alu_res.prod, b: {h_r, 4'd0}};
      default: begin
      end
    endcase
  end

  // result word
  assign out_ch.event_kind = res_r[k_r].kind;
  assign out_ch.button     = res_r[k_r].button;
  assign out_ch.pressed    = res_r[k_r].pressed;
  assign out_ch.pos_x      = res_r[k_r].pos_x;
  assign out_ch.pos_y      = res_r[k_r].pos_y;
  assign out_ch.wheel      = res_r[k_r].wheel;
  assign out_ch.last       = (k_r == nres_r - 2'd1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      phase_r <= PH_IDLE;
      count_r <= '0;
      lp_r    <= '0;
      nres_r  <= '0;
      k_r     <= '0;
      idx_r   <= '0;
      wp_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      lp_r    <= lp_nxt;
      nres_r  <= nres_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
      wp_r    <= wp_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    id_r   <= id_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    sx_r   <= sx_nxt;
    dist_r <= dist_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

[src/tgp_chk.sv]
// ----------------------------------------------------------------------------
// tgp_chk: port-level checks for the touch-to-pointer block
// Watches the channel handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // no new event taken while words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output word pending");

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn under stall");

  // after the final word the block is ready again
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("not ready after final word");

  // reset leaves the block ready with nothing to send
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind touch_gesture_to_pointer_top tgp_chk u_tgp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);

`default_nettype wire

[bench/touch_gesture_to_pointer_top_tb.sv]
// ----------------------------------------------------------------------------
// touch_gesture_to_pointer_top_tb: self-checking bench for touch-to-pointer
// Feeds finger down/up/motion words through the input channel in random
// bursts, predicts each pointer word from a behavioural model of the finger
// table and phase machine, and checks words on a randomly stalled output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module touch_gesture_to_pointer_top_tb;
  import tgp_pkg::*;

  localparam int MAXF      = 10;
  localparam int CYC_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] finger_id;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
  } touch_t;

  typedef struct packed {
    res_t r;
    logic last;
  } ptr_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tgp_in_if  in_ch ();
  tgp_out_if out_ch ();
  tgp_cfg_if cfg_ch ();

  touch_gesture_to_pointer_top #(.MAX_FINGERS(MAXF)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [11:0] m_width  = RST_WIDTH;
  logic [11:0] m_height = RST_HEIGHT;
  logic [15:0] m_gain   = RST_GAIN;
  logic [15:0] m_ids [MAXF];
  logic [15:0] m_xs [MAXF];
  logic [15:0] m_ys [MAXF];
  int          m_count = 0;
  phase_t      m_phase = PH_IDLE;
  logic [17:0] m_pinch = '0;

  touch_t    pending_words[$];
  ptr_word_t expected_words[$];
  int        n_fail = 0;
  longint    cycles = 0;

  // stimulus-side shadow of the table, to build sensible sequences
  logic [15:0] live_ids[$];

  function automatic logic [17:0] isqrt(input logic [33:0] v);
    logic [33:0] res, bit_v, val;
    val = v;
    res = '0;
    bit_v = 34'h1 << 32;
    while (bit_v > val) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (val >= res + bit_v) begin
        val = val - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[17:0];
  endfunction

  function automatic logic [17:0] pinch_of_pair();
    logic [33:0] dx, dy;
    dx = (m_xs[0] >= m_xs[1]) ? m_xs[0] - m_xs[1] : m_xs[1] - m_xs[0];
    dy = (m_ys[0] >= m_ys[1]) ? m_ys[0] - m_ys[1] : m_ys[1] - m_ys[0];
    return isqrt(dx * dx + dy * dy);
  endfunction

  task automatic push_word(input res_t r);
    ptr_word_t w;
    w.r = r;
    w.last = 1'b0;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic push_pos(input logic [15:0] x, input logic [15:0] y);
    res_t r;
    r = '0;
    r.kind = EV_POS;
    r.pos_x = x;
    r.pos_y = y;
    push_word(r);
  endtask

  task automatic push_btn(input logic b, input logic p);
    res_t r;
    r = '0;
    r.kind = EV_BTN;
    r.button = b;
    r.pressed = p;
    push_word(r);
  endtask

  task automatic push_centroid();
    logic [16:0] sx, sy;
    sx = m_xs[0] + m_xs[1];
    sy = m_ys[0] + m_ys[1];
    push_pos(sx[16:1], sy[16:1]);
  endtask

  // work out the pointer words a touch word causes and update the model
  task automatic predict_pointer(input touch_t t);
    logic [31:0] px, py;
    logic [17:0] pinch_now, mag;
    logic [49:0] q;
    int i, before_n;
    logic signed [15:0] whl;
    res_t r;
    if (m_width == 0 || m_height == 0 || t.command == CMD_RSVD) return;
    px = (32'(t.norm_x) * m_width) >> 12;
    py = (32'(t.norm_y) * m_height) >> 12;
    before_n = expected_words.size();
    if (t.command == CMD_DOWN) begin
      if (m_count >= MAXF) return;
      m_ids[m_count] = t.finger_id;
      m_xs[m_count] = px[15:0];
      m_ys[m_count] = py[15:0];
      m_count++;
    end else begin
      for (i = 0; i < m_count; i++)
        if (m_ids[i] == t.finger_id) break;
      if (i >= m_count) return;
      if (t.command == CMD_UP) begin
        for (; i + 1 < m_count; i++) begin
          m_ids[i] = m_ids[i+1];
          m_xs[i] = m_xs[i+1];
          m_ys[i] = m_ys[i+1];
        end
        m_count--;
      end else begin
        m_xs[i] = px[15:0];
        m_ys[i] = py[15:0];
      end
    end
    if (m_phase == PH_IDLE && m_count == 1) begin
      push_pos(m_xs[0], m_ys[0]);
      push_btn(BTN_LEFT, 1'b1);
      m_phase = PH_SINGLE;
    end else if (m_phase == PH_SINGLE && m_count >= 2) begin
      push_btn(BTN_LEFT, 1'b0);
      push_centroid();
      push_btn(BTN_RIGHT, 1'b1);
      m_pinch = pinch_of_pair();
      m_phase = PH_MULTI;
    end else if (m_phase == PH_SINGLE && m_count == 0) begin
      push_btn(BTN_LEFT, 1'b0);
      m_phase = PH_IDLE;
    end else if (m_phase == PH_MULTI && m_count < 2) begin
      push_btn(BTN_RIGHT, 1'b0);
      m_phase = (m_count == 0) ? PH_IDLE : PH_ENDED;
    end else if (m_phase == PH_ENDED && m_count == 0) begin
      m_phase = PH_IDLE;
    end else if (m_phase == PH_SINGLE && t.command == CMD_MOTION) begin
      push_pos(m_xs[0], m_ys[0]);
    end else if (m_phase == PH_MULTI && t.command == CMD_UP) begin
      // extra finger lifted: re-anchor without a wheel step
      push_centroid();
      m_pinch = pinch_of_pair();
    end else if (m_phase == PH_MULTI && t.command == CMD_MOTION) begin
      push_centroid();
      pinch_now = pinch_of_pair();
      mag = (pinch_now < m_pinch) ? m_pinch - pinch_now : pinch_now - m_pinch;
      q = (50'(mag) * m_gain) / (50'(m_height) * 16);
      if (pinch_now < m_pinch) whl = (q > 32768) ? -16'sd32768 : -$signed(16'(q));
      else whl = (q > 32767) ? 16'sd32767 : $signed(16'(q));
      if (whl != 0) begin
        r = '0;
        r.kind = EV_WHEEL;
        r.wheel = whl;
        push_word(r);
      end
      m_pinch = pinch_now;
    end
    if (expected_words.size() > before_n)
      expected_words[expected_words.size()-1].last = 1'b1;
  endtask

  // driver: bursts and gaps, fed from the pending queue
  int  gap_left = 0, burst_left = 0;
  logic hold_off = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_pointer(pending_words.pop_front());
        burst_left--;
      end
      if (burst_left <= 0 && gap_left <= 0) begin
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        burst_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) gap_left--;
      if (pending_words.size() > 0 && gap_left == 0 && !hold_off) begin
        in_ch.valid     <= 1'b1;
        in_ch.command   <= pending_words[0].command;
        in_ch.finger_id <= pending_words[0].finger_id;
        in_ch.norm_x    <= pending_words[0].norm_x;
        in_ch.norm_y    <= pending_words[0].norm_y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: random stall pattern, compare each word with the oldest expectation
  int stall_mode = 0;
  always @(posedge clk) begin
    ptr_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected pointer word kind=%0d", out_ch.event_kind);
          n_fail++;
        end else begin
          e = expected_words.pop_front();
          if (out_ch.event_kind !== e.r.kind) begin
            $error("event_kind exp %0d got %0d", e.r.kind, out_ch.event_kind); n_fail++;
          end
          if (out_ch.button !== e.r.button) begin
            $error("button exp %0d got %0d", e.r.button, out_ch.button); n_fail++;
          end
          if (out_ch.pressed !== e.r.pressed) begin
            $error("pressed exp %0d got %0d", e.r.pressed, out_ch.pressed); n_fail++;
          end
          if (out_ch.pos_x !== e.r.pos_x) begin
            $error("pos_x exp %0d got %0d", e.r.pos_x, out_ch.pos_x); n_fail++;
          end
          if (out_ch.pos_y !== e.r.pos_y) begin
            $error("pos_y exp %0d got %0d", e.r.pos_y, out_ch.pos_y); n_fail++;
          end
          if (out_ch.wheel !== e.r.wheel) begin
            $error("wheel exp %0d got %0d", e.r.wheel, out_ch.wheel); n_fail++;
          end
          if (out_ch.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_ch.last); n_fail++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_touch(input logic [1:0] c, input logic [15:0] id,
                           input logic [15:0] x, input logic [15:0] y);
    touch_t t;
    t.command = c;
    t.finger_id = id;
    t.norm_x = x;
    t.norm_y = y;
    pending_words.insert(pending_words.size(), t);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WIDTH:  m_width = val[11:0];
      REG_HEIGHT: m_height = val[11:0];
      default:    m_gain = val;
    endcase
  endtask

  task automatic rand_xy(output logic [15:0] x, output logic [15:0] y);
    case ($urandom_range(0, 5))
      0: begin x = 16'h0000; y = 16'hFFFF; end
      1: begin x = 16'hFFFF; y = 16'h0000; end
      default: begin x = 16'($urandom); y = 16'($urandom); end
    endcase
  endtask

  // one random well-formed touch episode, mixed with some noise
  task automatic add_episode();
    logic [15:0] x, y, id;
    int k, n_down, steps;
    n_down = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    for (k = 0; k < n_down; k++) begin
      id = ($urandom_range(0, 15) == 0 && live_ids.size() > 0) ? live_ids[0]
                                                               : 16'($urandom);
      rand_xy(x, y);
      add_touch(CMD_DOWN, id, x, y);
      live_ids.insert(live_ids.size(), id);
    end
    steps = $urandom_range(1, 8);
    for (k = 0; k < steps; k++) begin
      rand_xy(x, y);
      case ($urandom_range(0, 9))
        0: add_touch(CMD_RSVD, 16'($urandom), x, y);
        1: add_touch(CMD_MOTION, 16'($urandom), x, y);
        2: add_touch(CMD_UP, 16'($urandom), x, y);
        default: add_touch(CMD_MOTION, live_ids[$urandom_range(0, live_ids.size()-1)], x, y);
      endcase
    end
    while (live_ids.size() > 0) begin
      k = $urandom_range(0, live_ids.size()-1);
      rand_xy(x, y);
      add_touch(CMD_UP, live_ids[k], x, y);
      live_ids.delete(k);
      if ($urandom_range(0, 1)) begin
        if (live_ids.size() > 0) begin
          rand_xy(x, y);
          add_touch(CMD_MOTION, live_ids[0], x, y);
        end
      end
    end
  endtask

  initial begin
    int k, phase_n;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_DOWN;
    in_ch.finger_id = '0;
    in_ch.norm_x = '0;
    in_ch.norm_y = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WIDTH;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single drag, pinch, extra finger lifted, duplicate, full table
    add_touch(CMD_MOTION, 16'h0007, 16'h1000, 16'h1000);
    add_touch(CMD_DOWN, 16'h0000, 16'h0000, 16'h0000);
    add_touch(CMD_MOTION, 16'h0000, 16'hFFFF, 16'hFFFF);
    add_touch(CMD_DOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_touch(CMD_MOTION, 16'hFFFF, 16'h8000, 16'h8000);
    add_touch(CMD_MOTION, 16'h0000, 16'h7FFF, 16'h8000);
    add_touch(CMD_DOWN, 16'hFFFF, 16'h1234, 16'h5678);
    add_touch(CMD_UP, 16'hFFFF, 16'h0000, 16'h0000);
    add_touch(CMD_RSVD, 16'h0000, 16'h0000, 16'h0000);
    add_touch(CMD_UP, 16'hFFFF, 16'h0000, 16'h0000);
    add_touch(CMD_MOTION, 16'h0000, 16'h4000, 16'h4000);
    add_touch(CMD_UP, 16'h0000, 16'h0000, 16'h0000);
    for (k = 0; k < 11; k++) add_touch(CMD_DOWN, 16'(k + 100), 16'(k * 5000), 16'(k * 3000));
    for (k = 0; k < 10; k++) add_touch(CMD_UP, 16'(k + 100), 16'h0, 16'h0);
    wait_drained();

    // random phases, each with its own register setting and drained at its end; phase 5 starts with a hold-off
    for (phase_n = 0; phase_n < 7; phase_n++) begin
      case (phase_n)
        0: begin write_reg(REG_WIDTH, 16'd4095); write_reg(REG_HEIGHT, 16'd4095);
                 write_reg(REG_GAIN, 16'hFFFF); end
        1: begin write_reg(REG_WIDTH, 16'd1); write_reg(REG_HEIGHT, 16'd1);
                 write_reg(REG_GAIN, 16'h0000); end
        2: begin write_reg(REG_WIDTH, 16'd0); end
        3: begin write_reg(REG_WIDTH, 16'd800); write_reg(REG_HEIGHT, 16'd0); end
        4: begin write_reg(REG_HEIGHT, 16'd3); write_reg(REG_GAIN, 16'hFFFF); end
        5: begin write_reg(REG_WIDTH, 16'($urandom_range(1, 4095)));
                 write_reg(REG_HEIGHT, 16'($urandom_range(1, 4095)));
                 write_reg(REG_GAIN, 16'($urandom)); end
        default: begin write_reg(REG_WIDTH, 16'hF780); write_reg(REG_HEIGHT, 16'h0438);
                       write_reg(REG_GAIN, 16'd2560); end
      endcase
      k = 0;
      while (pending_words.size() < ((phase_n == 2 || phase_n == 3) ? 15 : 60))
        add_episode();
      hold_off = (phase_n == 5);
      if (hold_off) begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_drained();
    end

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
